[design/subtract_with_carry_rng_macros.svh]
// Assertion macros shared by the subtract-with-carry generator RTL.
// Included by subtract_with_carry_rng, which checks its own logic; no other dependencies.
`ifndef SUBTRACT_WITH_CARRY_RNG_MACROS_SVH
`define SUBTRACT_WITH_CARRY_RNG_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define SWC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swc same-cycle check failed");

// Check that cons holds in the cycle after ante, outside reset.
`define SWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swc next-cycle check failed");

`endif

[design/swc_pkg.sv]
// Package for the subtract-with-carry generator: defaults, widths, item codes.
// No dependencies; used by subtract_with_carry_rng and by the bench.
`timescale 1ns / 1ps
`default_nettype none

package swc_pkg;

   // Default lags and word width of the generator
   localparam int SHORT_LAG_DEF = 273;
   localparam int LONG_LAG_DEF  = 607;
   localparam int WORD_BITS_DEF = 64;

   // Port widths fixed by the stream words
   localparam int DATA_BITS = 64;
   localparam int FRAC_BITS = 32;

   // Item kind carried on the input tuser
   typedef enum logic {
      FUNC_SEED = 1'b0,
      FUNC_GEN  = 1'b1
   } func_type;

endpackage

`default_nettype wire

[design/swc_cell.sv]
// One cell of the history chain: holds one word, takes its neighbor's word on shift.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
`default_nettype none

module swc_cell #(
   parameter int WORD_BITS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift_en,
   input  wire logic [WORD_BITS-1:0] prev_word,
   output logic      [WORD_BITS-1:0] word_out
);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   // Take the neighbor's word on shift, otherwise hold
   always_comb begin
      word_in = shift_en ? prev_word : word_ff;
   end

   // Clear to zero on reset so unseeded history reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

[design/swc_chain.sv]
// Row of swc_cell instances forming the word history; taps at both lags.
// Depends on swc_cell.
`timescale 1ns / 1ps
`default_nettype none

module swc_chain #(
   parameter int WORD_BITS = 64,
   parameter int SHORT_LAG = 273,
   parameter int LONG_LAG  = 607
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift_en,
   input  wire logic [WORD_BITS-1:0] head_word,
   output logic      [WORD_BITS-1:0] short_tap,
   output logic      [WORD_BITS-1:0] long_tap
);

   // Only as many cells as the longer lag; older words are never read
   localparam int CHAIN_LEN = (SHORT_LAG > LONG_LAG) ? SHORT_LAG : LONG_LAG;

   // link[k] is the word stored k items ago (link[0] is the incoming word)
   logic [WORD_BITS-1:0] link [CHAIN_LEN+1];

   assign link[0] = head_word;

   // Build the row of cells, each fed by its upstream neighbor
   for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
      swc_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .prev_word (link[k]),
         .word_out  (link[k+1])
      );
   end

   // Tap the words written SHORT_LAG and LONG_LAG items back
   assign short_tap = link[SHORT_LAG];
   assign long_tap  = link[LONG_LAG];

endmodule

`default_nettype wire

[design/subtract_with_carry_rng.sv]
// A generate word is registered into the rsp output register, or into the skid register
// when the output is stalled. Throughput: one word per cycle while the skid register is
// free; the lag taps of the cell chain and the borrow register feed one wide subtract,
// so a new word can follow every cycle. req_tready drops only while the output skid
// register is full. Reset (synchronous, active high) clears every history cell, the
// borrow and the output valids at once; no clearing sweep follows.
`timescale 1ns / 1ps
`default_nettype none
`include "subtract_with_carry_rng_macros.svh"

module subtract_with_carry_rng #(
   parameter int SHORT_LAG = swc_pkg::SHORT_LAG_DEF,
   parameter int LONG_LAG  = swc_pkg::LONG_LAG_DEF,
   parameter int WORD_BITS = swc_pkg::WORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [swc_pkg::DATA_BITS-1:0] req_tdata,  // [63:0] seed_word
   input  wire logic                          req_tuser,  // [0] func
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [swc_pkg::DATA_BITS-1:0] rsp_tdata   // [31:0] frac_low, [63:32] frac_high
);

   logic                          req_accept;
   logic                          is_gen;
   logic [WORD_BITS-1:0]          short_tap;
   logic [WORD_BITS-1:0]          long_tap;
   logic [WORD_BITS:0]            diff;
   logic [WORD_BITS-1:0]          new_word;
   logic [WORD_BITS-1:0]          head_word;
   logic [swc_pkg::DATA_BITS-1:0] word_ext;
   logic                          res_valid;
   logic                          pop;

   logic                          borrow_ff;
   logic                          borrow_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [swc_pkg::DATA_BITS-1:0] rsp_data_ff;
   logic [swc_pkg::DATA_BITS-1:0] rsp_data_in;
   logic                          skid_valid_ff;
   logic                          skid_valid_in;
   logic [swc_pkg::DATA_BITS-1:0] skid_data_ff;
   logic [swc_pkg::DATA_BITS-1:0] skid_data_in;

   // Accept while the skid register is free
   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign is_gen     = (swc_pkg::func_type'(req_tuser) == swc_pkg::FUNC_GEN);

   // History chain, shifted once per accepted word of either kind
   swc_chain #(
      .WORD_BITS (WORD_BITS),
      .SHORT_LAG (SHORT_LAG),
      .LONG_LAG  (LONG_LAG)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (req_accept),
      .head_word (head_word),
      .short_tap (short_tap),
      .long_tap  (long_tap)
   );

   // Subtract with borrow; the top bit of the wide difference is the new borrow
   always_comb begin
      diff = {1'b0, short_tap} - {1'b0, long_tap} - {{WORD_BITS{1'b0}}, borrow_ff};
      new_word = diff[WORD_BITS-1:0];
   end

   // Store the generated word, or the seed cut to the word width
   assign head_word = is_gen ? new_word : req_tdata[WORD_BITS-1:0];

   // Zero-extend the word to the output word layout
   always_comb begin
      word_ext = '0;
      word_ext[WORD_BITS-1:0] = new_word;
   end

   // Update the borrow on generate words only
   always_comb begin
      borrow_in = (req_accept && is_gen) ? diff[WORD_BITS] : borrow_ff;
   end

   // Output register plus skid: drain skid first, park a new result when stalled
   assign res_valid = req_accept && is_gen;
   assign pop       = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = res_valid;
            rsp_data_in  = word_ext;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = word_ext;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         borrow_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         borrow_ff     <= borrow_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Skid register only fills behind a held output word
   `SWC_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)

   // Seed word into an empty output path produces nothing
   `SWC_ASSERT_NEXT(a_seed_no_word, clock, reset,
      req_accept && !is_gen && !rsp_valid_ff, !rsp_valid_ff)

   // Seed word leaves the borrow alone
   `SWC_ASSERT_NEXT(a_seed_keeps_borrow, clock, reset,
      req_accept && !is_gen, $stable(borrow_ff))

   // Generate word into an empty output path shows up next cycle unchanged
   `SWC_ASSERT_NEXT(a_gen_to_out, clock, reset,
      req_accept && is_gen && !rsp_valid_ff, rsp_valid_ff && rsp_data_ff == $past(word_ext))

endmodule

`default_nettype wire

[bench/swc_checker.sv]
`timescale 1ns / 1ps
// Checker for the subtract-with-carry generator: mirrors the history ring,
// predicts every generated word and compares it on the rsp channel.
// Depends on swc_pkg only; instantiated beside the block by tb_top.
module swc_checker
   import swc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [DATA_BITS-1:0] req_tdata,   // [63:0] seed_word
   input  logic                 req_tuser,   // [0] func
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [DATA_BITS-1:0] rsp_tdata,   // [31:0] frac_low, [63:32] frac_high
   output int                   fail_count,
   output int                   pending_words
);

   localparam int RING_DEPTH    = 1024;
   localparam int PTR_BITS      = $clog2(RING_DEPTH);
   localparam int REPORT_LIMIT  = 10;

   // Upper half first so the struct lines up with rsp_tdata
   typedef struct packed {
      logic [FRAC_BITS-1:0] frac_high;
      logic [FRAC_BITS-1:0] frac_low;
   } frac_pair_t;

   logic [WORD_BITS_DEF-1:0] history [RING_DEPTH];
   logic [PTR_BITS-1:0]      write_ptr;
   logic                     borrow;
   frac_pair_t               expected_fracs [$];

   initial begin
      fail_count    = 0;
      pending_words = 0;
   end

   // Count a mismatch; print only the first few
   task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] want,
                                  input logic [DATA_BITS-1:0] got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t swc_checker: %s mismatch, expected %h got %h", $time, what, want, got);
   endtask

   // Apply one accepted word to the mirrored ring; queue the fractions it yields
   function automatic void advance_ring(input func_type kind,
                                        input logic [DATA_BITS-1:0] seed);
      logic [PTR_BITS-1:0]    short_tap;
      logic [PTR_BITS-1:0]    long_tap;
      logic [WORD_BITS_DEF:0] diff;
      logic [DATA_BITS-1:0]   word;
      if (kind == FUNC_SEED) begin
         // seeding leaves the borrow alone
         history[write_ptr] = seed[WORD_BITS_DEF-1:0];
      end else begin
         short_tap = write_ptr - PTR_BITS'(SHORT_LAG_DEF);
         long_tap  = write_ptr - PTR_BITS'(LONG_LAG_DEF);
         // one extra bit on top catches the borrow out of the subtract
         diff = {1'b0, history[short_tap]} - {1'b0, history[long_tap]} - borrow;
         borrow = diff[WORD_BITS_DEF];
         history[write_ptr] = diff[WORD_BITS_DEF-1:0];
         word = DATA_BITS'(diff[WORD_BITS_DEF-1:0]);
         expected_fracs.push_back(frac_pair_t'(word));
      end
      write_ptr = write_ptr + 1'b1;
   endfunction

   // Check results first, then advance the prediction with the new request
   always @(posedge clock) begin
      frac_pair_t want;
      frac_pair_t got;
      if (reset) begin
         foreach (history[i]) history[i] = '0;
         write_ptr = '0;
         borrow    = 1'b0;
         expected_fracs.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = frac_pair_t'(rsp_tdata);
            if (expected_fracs.size() == 0) begin
               report_mismatch("unexpected word", 'x, rsp_tdata);
            end else begin
               want = expected_fracs.pop_front();
               if (got.frac_low !== want.frac_low)
                  report_mismatch("frac_low", DATA_BITS'(want.frac_low),
                                  DATA_BITS'(got.frac_low));
               if (got.frac_high !== want.frac_high)
                  report_mismatch("frac_high", DATA_BITS'(want.frac_high),
                                  DATA_BITS'(got.frac_high));
            end
         end
         if (req_tvalid && req_tready)
            advance_ring(func_type'(req_tuser), req_tdata);
      end
      pending_words = expected_fracs.size();
   end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Top of the subtract-with-carry generator bench: clock, reset, stimulus and verdict.
// Depends on swc_pkg, subtract_with_carry_rng and swc_checker.
module tb_top;
   import swc_pkg::*;

   localparam int CLOCK_HALF   = 10;
   localparam int RESET_CYCLES = 11;
   localparam int PHASE_WORDS  = 350;
   localparam int PHASES       = 4;
   localparam int HOLD_CYCLES  = 80;
   localparam int HOLD_WORDS   = 24;
   localparam int FLUSH_CYCLES = 8;
   localparam int QUIET_LIMIT  = 2000;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata  = '0;    // [63:0] seed_word
   logic                 req_tuser  = 1'b0;  // [0] func
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;          // [31:0] frac_low, [63:32] frac_high

   int fail_count;
   int pending_words;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int quiet_cycles   = 0;
   logic [DATA_BITS-1:0] last_seed = '0;

   subtract_with_carry_rng uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   swc_checker ring_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // End the run if nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [DATA_BITS-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Mostly random seeds, with extremes and repeats so equal taps show up
   function automatic logic [DATA_BITS-1:0] pick_seed();
      logic [DATA_BITS-1:0] w;
      case ($urandom_range(9))
         0: w = '0;
         1: w = '1;
         2: w = last_seed;
         default: w = random_word();
      endcase
      last_seed = w;
      return w;
   endfunction

   // Offer one word after a random gap; return just past the accepting edge
   task automatic send_word(input func_type kind, input logic [DATA_BITS-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   // Hold the sender until every predicted word has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      @(posedge clock);
   endtask

   // Random mix of seed bursts and generate runs of random length
   task automatic run_random_words(input int count);
      int sent;
      int run_len;
      bit seeding;
      sent = 0;
      while (sent < count) begin
         seeding = ($urandom_range(99) < 30);
         run_len = seeding ? $urandom_range(1, 40) : $urandom_range(1, 60);
         for (int k = 0; k < run_len && sent < count; k++) begin
            if (seeding)
               send_word(FUNC_SEED, pick_seed());
            else
               send_word(FUNC_GEN, random_word());
            sent++;
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // generate on an empty ring: all-zero words, seed field ignored
      send_word(FUNC_GEN, '0);
      send_word(FUNC_GEN, '1);
      send_word(FUNC_GEN, 64'h5555_5555_5555_5555);
      send_word(FUNC_GEN, 64'hAAAA_AAAA_AAAA_AAAA);
      // seed the extremes and a few edge patterns
      send_word(FUNC_SEED, '0);
      send_word(FUNC_SEED, '1);
      send_word(FUNC_SEED, 64'h5555_5555_5555_5555);
      send_word(FUNC_SEED, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(FUNC_SEED, 64'h8000_0000_0000_0001);
      send_word(FUNC_SEED, 64'h0000_0001_FFFF_FFFF);
      send_word(FUNC_SEED, 64'hFFFF_FFFF_0000_0000);
      send_word(FUNC_SEED, 64'h0000_0000_FFFF_FFFF);
      // generate between seeds; borrow must survive the seeds untouched
      send_word(FUNC_GEN, 64'hFFFF_FFFF_0000_0000);
      send_word(FUNC_SEED, 64'h7FFF_FFFF_FFFF_FFFF);
      send_word(FUNC_GEN, 64'h0000_0000_FFFF_FFFF);
      send_word(FUNC_SEED, 64'h0000_0000_0000_0001);
      send_word(FUNC_GEN, 64'h8000_0000_0000_0000);
      send_word(FUNC_GEN, 64'h0123_4567_89AB_CDEF);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 71;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 71;
            end
            default: begin
               send_idle_pct  = 7;
               recv_stall_pct = 7;
            end
         endcase
         run_random_words(PHASE_WORDS);
         if (phase == 0) begin
            // back-pressure: receiver holds off while the sender keeps pushing
            hold_requests++;
            repeat (HOLD_WORDS) send_word(FUNC_GEN, random_word());
         end
         wait_drained();
      end

      repeat (FLUSH_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/swc_pkg.sv
design/swc_cell.sv
design/swc_chain.sv
design/subtract_with_carry_rng.sv
bench/swc_checker.sv
bench/tb_top.sv
